// ===== rtl/core/cdc_pkg.sv =====
package cdc_pkg;

  localparam int QUALIFY_RUN = 4;
  localparam int HIST_W = 8;
  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

  localparam logic [HIST_W-1:0] ACTIVE_MASK =
    (QUALIFY_RUN >= HIST_W) ? {HIST_W{1'b1}} : HIST_W'((1 << QUALIFY_RUN) - 1);
  // history bit is 1 for an inactive sample: old samples inactive, newest run active
  localparam logic [HIST_W-1:0] EVENT_PATTERN = ~ACTIVE_MASK;

  typedef struct packed {
    logic [HIST_W-1:0]    go_hist;
    logic [HIST_W-1:0]    clr_hist;
    logic [HIST_W-1:0]    sense_hist;
    logic                 card;
    logic [TIMEOUT_W-1:0] elapsed;
    logic                 fault;
    logic                 motor;
    logic                 led;
  } cdc_state_t;

  typedef struct packed {
    logic game_over;
    logic clear_alert;
    logic card_sense;
  } cdc_pins_t;

  function automatic logic [HIST_W-1:0] shift_hist(input logic [HIST_W-1:0] hist,
                                                   input logic inactive);
    shift_hist = {hist[HIST_W-2:0], inactive};
  endfunction

endpackage

// ===== rtl/core/cdc_step.sv =====
module cdc_step (
  input  cdc_pkg::cdc_state_t       cur,
  input  cdc_pkg::cdc_pins_t        pins,
  input  logic [cdc_pkg::TIMEOUT_W-1:0] timeout,
  output cdc_pkg::cdc_state_t       nxt
);

  logic [cdc_pkg::HIST_W-1:0] sense_shifted;

  always_comb begin
    nxt = cur;
    sense_shifted = cdc_pkg::shift_hist(cur.sense_hist, pins.card_sense);

    nxt.go_hist = cdc_pkg::shift_hist(cur.go_hist, ~pins.game_over);
    if (nxt.go_hist == cdc_pkg::EVENT_PATTERN) begin
      nxt.card = 1'b1;
    end

    nxt.clr_hist = cdc_pkg::shift_hist(cur.clr_hist, pins.clear_alert);
    if (nxt.clr_hist == cdc_pkg::EVENT_PATTERN && cur.fault) begin
      nxt.fault = 1'b0;
      nxt.led   = 1'b0;
    end

    // dispensing tick: count, run motor, watch the card sensor, raise the timeout fault
    if (!nxt.fault && nxt.card) begin
      nxt.elapsed    = cur.elapsed + 1'b1;
      nxt.motor      = 1'b1;
      nxt.sense_hist = sense_shifted;
      if (sense_shifted == cdc_pkg::EVENT_PATTERN) begin
        nxt.card    = 1'b0;
        nxt.elapsed = '0;
        nxt.motor   = 1'b0;
      end
      if (nxt.elapsed >= timeout) begin
        nxt.motor   = 1'b0;
        nxt.led     = 1'b1;
        nxt.elapsed = '0;
        nxt.fault   = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/card_dispense_controller_unit.sv =====
// Card dispenser controller. Each input word is one timer tick with three raw pin
// levels; each tick yields one output word holding the motor, alert lamp, timeout
// fault and card-waiting flags as they stand after that tick. One tick is taken
// every clock cycle while the output is not stalled; a word's result passes from the
// input register to the result register, which the state update loads when the
// output is free. The timeout register is written through the cfg channel, which is
// always ready, and should be changed only while no ticks are in flight.
module card_dispense_controller_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // game_over_level, clear_alert_level, card_sense_level
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // motor_run, alert_led, timeout_error, card_waiting
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [15:0] cfg_data       // dispense_timeout
);

  logic                              in_valid;
  cdc_pkg::cdc_pins_t                in_pins;
  logic [cdc_pkg::TIMEOUT_W-1:0]     timeout;
  cdc_pkg::cdc_state_t               st;
  cdc_pkg::cdc_state_t               st_next;
  logic                              out_free;
  logic                              advance;
  logic [3:0]                        out_bits;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= cdc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pins.game_over   <= s_axis_tdata[0];
      in_pins.clear_alert <= s_axis_tdata[1];
      in_pins.card_sense  <= s_axis_tdata[2];
    end
  end

  cdc_step u_step (
    .cur     (st),
    .pins    (in_pins),
    .timeout (timeout),
    .nxt     (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bits <= {st_next.card, st_next.fault, st_next.led, st_next.motor};
    end
  end

  assign m_axis_tdata = {4'b0000, out_bits};

`ifndef NO_ASSERTIONS
  a_led_tracks_fault: assert property (@(posedge clk) disable iff (rst)
    st.led == st.fault) else $error("alert lamp out of step with fault");

  a_no_motor_in_fault: assert property (@(posedge clk) disable iff (rst)
    !(st.motor && st.fault)) else $error("motor running while faulted");

  a_motor_needs_card: assert property (@(posedge clk) disable iff (rst)
    st.motor |-> st.card) else $error("motor running with no card pending");

  a_in_word_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_pins)))
    else $error("stalled input word lost");
`endif

endmodule
